### hdl/ttempo_pkg.sv
// ----------------------------------------------------------------------------
// ttempo_pkg
// Shared types, constants and register codes of the tap tempo estimator.
// ----------------------------------------------------------------------------
package ttempo_pkg;

  localparam int WINDOW_TAPS_DEF = 8;

  localparam int TIME_W  = 32;
  localparam int GAP_W   = 24;
  localparam int BPM_W   = 16;
  localparam int TAPS_W  = 4;
  localparam int CENTI_W = 33;

  localparam logic [CENTI_W-1:0] CENTI_MINUTE_US = 33'd6000000000;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [GAP_W-1:0] GAP_RESET = 24'd2000000;
  localparam logic [BPM_W-1:0] MIN_RESET = 16'd3000;
  localparam logic [BPM_W-1:0] MAX_RESET = 16'd30000;

  typedef enum logic [1:0] {
    REG_RESET_GAP = 2'd0,
    REG_MIN_BPM   = 2'd1,
    REG_MAX_BPM   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [GAP_W-1:0] reset_gap_us;
    logic [BPM_W-1:0] min_bpm_centi;
    logic [BPM_W-1:0] max_bpm_centi;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [BPM_W-1:0] quot;
  } div_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_SPAN,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### hdl/tap_tempo_estimator.sv
// ----------------------------------------------------------------------------
// tap_tempo_estimator: tempo in hundredths of BPM from the spacing of taps.
// A tap stalls the input from its transfer until its result is taken into the
// output register; the divide is skipped below two taps or on a zero span.
// The divider is bit-serial, one quotient bit per cycle.
// Synchronous reset clears control state and loads the register defaults.
// ----------------------------------------------------------------------------
module tap_tempo_estimator #(
  parameter int WINDOW_TAPS = ttempo_pkg::WINDOW_TAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ttempo_pkg::TIME_W-1:0]       in_tap_time_us,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ttempo_pkg::BPM_W-1:0]        out_bpm_centi,
  output logic [ttempo_pkg::TAPS_W-1:0]       out_taps_in_window,
  output logic                                out_session_restarted,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ttempo_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ttempo_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ttempo_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready
);

  localparam int IdxW = $clog2(WINDOW_TAPS);
  localparam int CntW = $clog2(WINDOW_TAPS + 1);
  localparam int SumW = CntW + 1;
  localparam int NumW = ttempo_pkg::CENTI_W + IdxW;
  localparam int TW   = ttempo_pkg::TIME_W;
  localparam int BW   = ttempo_pkg::BPM_W;

  ttempo_pkg::cfg_t        cfg;
  ttempo_pkg::div_status_t div_st;
  ttempo_pkg::state_t      state_r, state_nxt;

  logic [IdxW-1:0] head_r, head_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [TW-1:0]   last_r, last_nxt;
  logic [BW-1:0]   held_bpm_r, held_bpm_nxt;
  logic            restart_r, restart_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [BW-1:0]                 out_bpm_r, out_bpm_nxt;
  logic [ttempo_pkg::TAPS_W-1:0] out_taps_r, out_taps_nxt;
  logic                          out_restart_r, out_restart_nxt;

  logic            in_accept;
  logic [TW-1:0]   gap;
  logic            restart;
  logic [IdxW-1:0] head_base;
  logic [CntW-1:0] count_base;
  logic [SumW-1:0] oldest_sum;
  logic [IdxW-1:0] oldest_idx;
  logic [TW-1:0]   ring_rdata;
  logic [TW-1:0]   span;
  logic [IdxW-1:0] cnt_m1;
  logic [NumW-1:0] numer;
  logic            div_start;
  logic [BW-1:0]   bpm_raised;
  logic [BW-1:0]   bpm_clamped;
  logic            out_free;

  ttempo_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ttempo_ram #(
    .WIDTH (TW),
    .DEPTH (WINDOW_TAPS)
  ) u_ram (
    .clk   (clk),
    .we    (in_accept),
    .waddr (head_base),
    .wdata (in_tap_time_us),
    .raddr (oldest_idx),
    .rdata (ring_rdata)
  );

  ttempo_div #(
    .NUM_W (NumW)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (numer),
    .den    (span),
    .status (div_st)
  );

  assign in_stall   = (state_r != ttempo_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign gap        = in_tap_time_us - last_r;
  assign restart    = (count_r == '0) || (gap > TW'(cfg.reset_gap_us));
  assign head_base  = restart ? '0 : head_r;
  assign count_base = restart ? '0 : count_r;

  assign oldest_sum = SumW'(head_r) + SumW'(WINDOW_TAPS) - SumW'(count_r);
  assign oldest_idx = (oldest_sum >= SumW'(WINDOW_TAPS)) ?
                      IdxW'(oldest_sum - SumW'(WINDOW_TAPS)) : IdxW'(oldest_sum);

  assign span   = last_r - ring_rdata;
  assign cnt_m1 = IdxW'(count_r - CntW'(1));
  assign numer  = NumW'(ttempo_pkg::CENTI_MINUTE_US) * NumW'(cnt_m1);

  assign bpm_raised  = (div_st.quot < cfg.min_bpm_centi) ? cfg.min_bpm_centi : div_st.quot;
  assign bpm_clamped = (div_st.ovf || (bpm_raised > cfg.max_bpm_centi)) ?
                       cfg.max_bpm_centi : bpm_raised;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    last_nxt        = last_r;
    held_bpm_nxt    = held_bpm_r;
    restart_nxt     = restart_r;
    div_start       = 1'b0;
    out_valid_nxt   = out_valid_r && out_stall;
    out_bpm_nxt     = out_bpm_r;
    out_taps_nxt    = out_taps_r;
    out_restart_nxt = out_restart_r;
    unique case (state_r)
      ttempo_pkg::ST_IDLE: begin
        if (in_accept) begin
          restart_nxt = restart;
          last_nxt    = in_tap_time_us;
          head_nxt    = (head_base == IdxW'(WINDOW_TAPS - 1)) ? '0 : head_base + IdxW'(1);
          count_nxt   = (count_base < CntW'(WINDOW_TAPS)) ? count_base + CntW'(1) : count_base;
          state_nxt   = ttempo_pkg::ST_ADDR;
        end
      end
      ttempo_pkg::ST_ADDR: begin
        state_nxt = ttempo_pkg::ST_SPAN;
      end
      ttempo_pkg::ST_SPAN: begin
        if ((count_r >= CntW'(2)) && (span != '0)) begin
          div_start = 1'b1;
          state_nxt = ttempo_pkg::ST_DIV;
        end else begin
          state_nxt = ttempo_pkg::ST_DONE;
        end
      end
      ttempo_pkg::ST_DIV: begin
        if (div_st.done) begin
          held_bpm_nxt = bpm_clamped;
          state_nxt    = ttempo_pkg::ST_DONE;
        end
      end
      ttempo_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_bpm_nxt     = held_bpm_r;
          out_taps_nxt    = ttempo_pkg::TAPS_W'(count_r);
          out_restart_nxt = restart_r;
          state_nxt       = ttempo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ttempo_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttempo_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      last_r      <= '0;
      held_bpm_r  <= '0;
      restart_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      held_bpm_r  <= held_bpm_nxt;
      restart_r   <= restart_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_bpm_r     <= out_bpm_nxt;
    out_taps_r    <= out_taps_nxt;
    out_restart_r <= out_restart_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_bpm_centi         = out_bpm_r;
  assign out_taps_in_window    = out_taps_r;
  assign out_session_restarted = out_restart_r;

`ifndef SYNTHESIS
  a_stall_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ttempo_pkg::ST_DONE))
    else $error("result raised outside the completion state");

  a_held_only_on_divide: assert property (@(posedge clk) disable iff (!rst_n)
    !div_st.done |=> $stable(held_bpm_r))
    else $error("held tempo changed without a finished division");

  a_restart_single_tap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_session_restarted) |-> (out_taps_in_window == ttempo_pkg::TAPS_W'(1)))
    else $error("restarted session does not hold exactly one tap");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(WINDOW_TAPS))
    else $error("tap count exceeds the window");
`endif

endmodule

### hdl/ttempo_ram.sv
// ----------------------------------------------------------------------------
// ttempo_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module ttempo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/ttempo_cfg.sv
// ----------------------------------------------------------------------------
// ttempo_cfg
// APB register file holding the session gap and the tempo limits.
// ----------------------------------------------------------------------------
module ttempo_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ttempo_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ttempo_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ttempo_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready,
  output ttempo_pkg::cfg_t                    cfg_o
);

  ttempo_pkg::cfg_t     cfg_r;
  ttempo_pkg::cfg_t     cfg_nxt;
  ttempo_pkg::reg_idx_t idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = ttempo_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        ttempo_pkg::REG_RESET_GAP: begin
          cfg_nxt.reset_gap_us = pwdata[ttempo_pkg::GAP_W-1:0];
        end
        ttempo_pkg::REG_MIN_BPM: begin
          cfg_nxt.min_bpm_centi = pwdata[ttempo_pkg::BPM_W-1:0];
        end
        ttempo_pkg::REG_MAX_BPM: begin
          cfg_nxt.max_bpm_centi = pwdata[ttempo_pkg::BPM_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ttempo_pkg::REG_RESET_GAP: prdata = ttempo_pkg::APB_DATA_W'(cfg_r.reset_gap_us);
      ttempo_pkg::REG_MIN_BPM:   prdata = ttempo_pkg::APB_DATA_W'(cfg_r.min_bpm_centi);
      ttempo_pkg::REG_MAX_BPM:   prdata = ttempo_pkg::APB_DATA_W'(cfg_r.max_bpm_centi);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_gap_us  <= ttempo_pkg::GAP_RESET;
      cfg_r.min_bpm_centi <= ttempo_pkg::MIN_RESET;
      cfg_r.max_bpm_centi <= ttempo_pkg::MAX_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

### hdl/ttempo_div.sv
// ----------------------------------------------------------------------------
// ttempo_div
// Bit-serial restoring divider, one quotient bit per cycle, with a sticky
// flag for quotients that do not fit the tempo width.
// ----------------------------------------------------------------------------
module ttempo_div #(
  parameter int NUM_W = 36
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [NUM_W-1:0]                 num,
  input  logic [ttempo_pkg::TIME_W-1:0]    den,
  output ttempo_pkg::div_status_t          status
);

  localparam int StepW = $clog2(NUM_W + 1);
  localparam int TW    = ttempo_pkg::TIME_W;
  localparam int BW    = ttempo_pkg::BPM_W;

  logic [TW-1:0]    rem_r,  rem_nxt;
  logic [TW-1:0]    den_r,  den_nxt;
  logic [NUM_W-1:0] num_r,  num_nxt;
  logic [BW-1:0]    quo_r,  quo_nxt;
  logic             ovf_r,  ovf_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [TW:0]   trial;
  logic [TW+1:0] diff;
  logic          ge;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign ge    = !diff[TW+1];

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      den_nxt  = den;
      num_nxt  = num;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
      step_nxt = StepW'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[TW-1:0] : trial[TW-1:0];
      num_nxt  = {num_r[NUM_W-2:0], 1'b0};
      quo_nxt  = {quo_r[BW-2:0], ge};
      ovf_nxt  = ovf_r | quo_r[BW-1];
      step_nxt = step_r - StepW'(1);
      if (step_r == StepW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign status.done = done_r;
  assign status.ovf  = ovf_r;
  assign status.quot = quo_r;

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tap tempo estimator
// Taps are sent through a randomly idling driver, and each result is checked
// against a tempo predictor that tracks the tap window, the session restarts
// and the held tempo. The run passes through default, extreme, crossed-limit
// and random register settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW = ttempo_pkg::WINDOW_TAPS_DEF;

  typedef struct packed {
    logic [ttempo_pkg::BPM_W-1:0]  bpm;
    logic [ttempo_pkg::TAPS_W-1:0] taps;
    logic                          restarted;
  } tempo_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [ttempo_pkg::TIME_W-1:0]     in_tap_time_us = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [ttempo_pkg::BPM_W-1:0]      out_bpm_centi;
  logic [ttempo_pkg::TAPS_W-1:0]     out_taps_in_window;
  logic                              out_session_restarted;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [ttempo_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [ttempo_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [ttempo_pkg::APB_DATA_W-1:0] prdata;
  logic                              pready;

  tap_tempo_estimator dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_tap_time_us        (in_tap_time_us),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_bpm_centi         (out_bpm_centi),
    .out_taps_in_window    (out_taps_in_window),
    .out_session_restarted (out_session_restarted),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always #10 clk = ~clk;

  // Register copies and window state of the tempo predictor.
  logic [ttempo_pkg::GAP_W-1:0]  gap_limit = ttempo_pkg::GAP_RESET;
  logic [ttempo_pkg::BPM_W-1:0]  bpm_floor = ttempo_pkg::MIN_RESET;
  logic [ttempo_pkg::BPM_W-1:0]  bpm_ceil  = ttempo_pkg::MAX_RESET;
  logic [ttempo_pkg::TIME_W-1:0] hist_time [WINDOW];
  logic [2:0]                    hist_head = '0;
  logic [ttempo_pkg::TAPS_W-1:0] hist_count = '0;
  logic [ttempo_pkg::TIME_W-1:0] prev_tap = '0;
  logic [ttempo_pkg::BPM_W-1:0]  tempo_hold = '0;

  logic [ttempo_pkg::TIME_W-1:0] tap_queue [$];
  tempo_result_t                 tempo_expected [$];
  logic [ttempo_pkg::TIME_W-1:0] tap_clock = '0;
  int                            send_idle_pct = 0;
  int                            stall_pct = 0;
  int                            fault_count = 0;

  function automatic tempo_result_t predict_tempo(input logic [ttempo_pkg::TIME_W-1:0] t);
    logic [ttempo_pkg::TIME_W-1:0] since_last;
    logic [ttempo_pkg::TIME_W-1:0] span;
    logic [63:0]                   rate;
    logic [2:0]                    oldest;
    logic                          fresh;
    tempo_result_t                 r;
    since_last = t - prev_tap;
    fresh = (hist_count == 0) || (since_last > {8'd0, gap_limit});
    if (fresh) begin
      hist_count = '0;
      hist_head  = '0;
    end
    prev_tap = t;
    hist_time[hist_head] = t;
    hist_head = hist_head + 3'd1;
    if (hist_count < WINDOW) hist_count = hist_count + 4'd1;
    if (hist_count >= 2) begin
      oldest = hist_head - hist_count[2:0];
      span = t - hist_time[oldest];
      if (span != 0) begin
        rate = (64'(ttempo_pkg::CENTI_MINUTE_US) * 64'(hist_count - 4'd1)) / 64'(span);
        if (rate < bpm_floor) rate = 64'(bpm_floor);
        if (rate > bpm_ceil) rate = 64'(bpm_ceil);
        tempo_hold = rate[ttempo_pkg::BPM_W-1:0];
      end
    end
    r.bpm       = tempo_hold;
    r.taps      = hist_count;
    r.restarted = fresh;
    return r;
  endfunction

  task automatic queue_tap(input logic [ttempo_pkg::TIME_W-1:0] t);
    tap_queue = {tap_queue, t};
  endtask

  // Tap driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        tempo_expected = {tempo_expected, predict_tempo(in_tap_time_us)};
      if (!in_valid || !in_stall) begin
        if (tap_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid       <= 1'b1;
          in_tap_time_us <= tap_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    tempo_result_t want;
    tempo_result_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99, 0) < stall_pct);
      if (out_valid && !out_stall) begin
        got = '{out_bpm_centi, out_taps_in_window, out_session_restarted};
        if (tempo_expected.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: unexpected transfer bpm=%0d taps=%0d restart=%0b",
                     got.bpm, got.taps, got.restarted);
        end else begin
          want = tempo_expected.pop_front();
          if (got.bpm !== want.bpm || got.taps !== want.taps ||
              got.restarted !== want.restarted) begin
            fault_count++;
            if (fault_count <= 10)
              $display("mismatch: bpm %0d/%0d taps %0d/%0d restart %0b/%0b (exp/act)",
                       want.bpm, got.bpm, want.taps, got.taps,
                       want.restarted, got.restarted);
          end
        end
      end
    end
  end

  task automatic cfg_write(input ttempo_pkg::reg_idx_t idx, input logic [31:0] value);
    logic [31:0] junk;
    junk = $urandom();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (idx == ttempo_pkg::REG_RESET_GAP) ? {junk[31:24], value[23:0]}
                                                  : {junk[31:16], value[15:0]};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    unique case (idx)
      ttempo_pkg::REG_RESET_GAP: gap_limit = value[ttempo_pkg::GAP_W-1:0];
      ttempo_pkg::REG_MIN_BPM:   bpm_floor = value[ttempo_pkg::BPM_W-1:0];
      ttempo_pkg::REG_MAX_BPM:   bpm_ceil  = value[ttempo_pkg::BPM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (tap_queue.size() != 0 || in_valid || tempo_expected.size() != 0)
      @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  // Sessions of taps at a steady pace with jitter, with some stray spacings.
  task automatic queue_sessions(input int n_items);
    int          left;
    int          len;
    logic [31:0] pace;
    logic [31:0] stride;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(14, 1);
      if (len > left) len = left;
      if ($urandom_range(1, 0) == 0) tap_clock = $urandom();
      else tap_clock = tap_clock + gap_limit + 1 + $urandom_range(1000, 0);
      case ($urandom_range(3, 0))
        0:       pace = $urandom_range(1000, 0);
        1:       pace = $urandom_range(gap_limit, 0);
        2:       pace = 32'(gap_limit);
        default: pace = $urandom_range(600000, 150000);
      endcase
      for (int i = 0; i < len; i++) begin
        if (i > 0) begin
          stride = (pace > 100) ? pace - 100 + $urandom_range(200, 0) : pace;
          if (stride > 32'(gap_limit)) stride = 32'(gap_limit);
          if ($urandom_range(19, 0) == 0) stride = $urandom();
          tap_clock = tap_clock + stride;
        end
        queue_tap(tap_clock);
      end
      left -= len;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 20;
    stall_pct     = 85;
    // Single tap, zero span, steady taps, a restart just past the gap and a
    // tap exactly at the gap.
    queue_tap(32'd0);
    queue_tap(32'd0);
    queue_tap(32'd500000);
    queue_tap(32'd1000000);
    queue_tap(32'd3000001);
    queue_tap(32'd5000001);
    queue_tap(32'd5000101);
    // Very fast taps saturate at the maximum and overrun the window.
    tap_clock = 32'd5000101;
    for (int i = 0; i < 8; i++) begin
      tap_clock = tap_clock + 1;
      queue_tap(tap_clock);
    end
    // Timestamps wrapping through zero.
    queue_tap(32'hFFFF_FFF0);
    queue_tap(32'h0000_0010);
    queue_tap(32'h0007_A130);
    queue_tap(32'hFFFF_FFFF);
    queue_tap(32'h0000_0000);
    queue_sessions(180);
    wait_drained();

    cfg_write(ttempo_pkg::REG_RESET_GAP, 32'd16777215);
    cfg_write(ttempo_pkg::REG_MIN_BPM, 32'd100);
    cfg_write(ttempo_pkg::REG_MAX_BPM, 32'd60000);
    send_idle_pct = 85;
    stall_pct     = 20;
    queue_sessions(180);
    wait_drained();

    // Crossed limits: the maximum wins.
    cfg_write(ttempo_pkg::REG_RESET_GAP, 32'd1);
    cfg_write(ttempo_pkg::REG_MIN_BPM, 32'd60000);
    cfg_write(ttempo_pkg::REG_MAX_BPM, 32'd100);
    queue_sessions(60);
    wait_drained();

    cfg_write(ttempo_pkg::REG_RESET_GAP, $urandom_range(3000000, 200000));
    cfg_write(ttempo_pkg::REG_MIN_BPM, $urandom_range(10000, 100));
    cfg_write(ttempo_pkg::REG_MAX_BPM, $urandom_range(60000, 10000));
    send_idle_pct = 0;
    stall_pct     = 0;
    queue_sessions(180);
    wait_drained();

    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
